### sv/assert_macros.svh
// Assertion macros used by the port checker of the oscillator bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, suspended while arst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/wtob_pkg.sv
// Package of the wavetable oscillator bank: sizes, codes and shared types.
`timescale 1ns / 1ps

package wtob_pkg;

	localparam int NUM_OSC     = 4;
	localparam int TABLE_DEPTH = 256;
	localparam int DAC_BITS    = 12;

	localparam int ACTION_W  = 2;
	localparam int OSC_W     = 2;
	localparam int IDX_W     = 8;
	localparam int VAL_W     = 12;
	localparam int PHASE_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int SAMPLE_W  = 16;

	localparam int CNT_W     = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
	localparam int MEM_DEPTH = NUM_OSC * TABLE_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int PROD_W    = VAL_W + GAIN_W;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_TICK  = 2'd0;
	localparam action_t ACT_WRITE = 2'd1;
	localparam action_t ACT_SET   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             clear_mix;
		logic             issue;
		logic [CNT_W-1:0] osc;
		logic             wr_table;
		logic             set_osc;
		logic             load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

### sv/wtob_in_if.sv
// Input channel of the oscillator bank: one command word per handshake.
`timescale 1ns / 1ps

interface wtob_in_if;
	logic                          valid;
	logic                          ready;
	logic [wtob_pkg::ACTION_W-1:0] action;
	logic [wtob_pkg::OSC_W-1:0]    osc_index;
	logic [wtob_pkg::IDX_W-1:0]    table_index;
	logic [wtob_pkg::VAL_W-1:0]    table_value;
	logic [wtob_pkg::PHASE_W-1:0]  phase_step;
	logic [wtob_pkg::GAIN_W-1:0]   gain;

	modport source (
		output valid, action, osc_index, table_index, table_value, phase_step, gain,
		input  ready
	);
	modport sink (
		input  valid, action, osc_index, table_index, table_value, phase_step, gain,
		output ready
	);
endinterface

### sv/wtob_out_if.sv
// Output channel of the oscillator bank: one mixed sample word per handshake.
`timescale 1ns / 1ps

interface wtob_out_if;
	logic                          valid;
	logic                          ready;
	logic [wtob_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

### sv/wavetable_oscillator_bank_core.sv
// Top level of the wavetable oscillator bank: controller, datapath and channels.
`timescale 1ns / 1ps

// A table write or a set is taken at once, and the next word may follow straight after.
// A tick runs the oscillators one per cycle through the single read port of the
// wavetable memory and a two-stage multiply and mix pipeline, so the block is
// busy from the accepted tick through the drain states until it takes the next
// word, and stays busy while an earlier sample still waits in the output register.
// The finished sample stays in that register until taken, while table writes and
// sets go on. The wavetables have no reset; the host loads every entry that a tick
// can read before ticking.
module wavetable_oscillator_bank_core (
	input logic     clk,
	input logic     arst_n,
	wtob_in_if.sink   cmd,
	wtob_out_if.source result
);

	wtob_pkg::dp_cmd_t    dp_cmd;
	wtob_pkg::dp_status_t dp_status;

	wtob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.action    (cmd.action),
		.osc_index (cmd.osc_index),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	wtob_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.osc_index   (cmd.osc_index),
		.table_index (cmd.table_index),
		.table_value (cmd.table_value),
		.phase_step  (cmd.phase_step),
		.gain        (cmd.gain),
		.status      (dp_status),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.sample      (result.sample)
	);

endmodule

### sv/wtob_ctrl.sv
// Controller of the oscillator bank: command decode and the per-tick sequencer.
`timescale 1ns / 1ps

module wtob_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wtob_pkg::ACTION_W-1:0] action,
	input  logic [wtob_pkg::OSC_W-1:0]    osc_index,
	input  wtob_pkg::dp_status_t          status,
	output wtob_pkg::dp_cmd_t             cmd
);

	wtob_pkg::state_t               state_q, state_d;
	logic [wtob_pkg::CNT_W-1:0]     cnt_q;
	logic                           last_osc;
	logic                           osc_ok;
	logic                           accept;

	assign last_osc = (cnt_q == wtob_pkg::CNT_W'(wtob_pkg::NUM_OSC - 1));
	assign osc_ok   = (int'(osc_index) < wtob_pkg::NUM_OSC);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtob_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wtob_pkg::ST_RUN && !last_osc) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wtob_pkg::ST_IDLE: begin
				if (in_valid && action == wtob_pkg::ACT_TICK) begin
					state_d = wtob_pkg::ST_RUN;
				end
			end
			wtob_pkg::ST_RUN: begin
				if (last_osc) begin
					state_d = wtob_pkg::ST_DRAIN1;
				end
			end
			wtob_pkg::ST_DRAIN1: state_d = wtob_pkg::ST_DRAIN2;
			wtob_pkg::ST_DRAIN2: state_d = wtob_pkg::ST_DONE;
			wtob_pkg::ST_DONE: begin
				if (!status.out_busy) begin
					state_d = wtob_pkg::ST_IDLE;
				end
			end
			default: state_d = wtob_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.osc       = cnt_q;
		case (state_q)
			wtob_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.clear_mix = accept && action == wtob_pkg::ACT_TICK;
				cmd.wr_table  = accept && action == wtob_pkg::ACT_WRITE && osc_ok;
				cmd.set_osc   = accept && action == wtob_pkg::ACT_SET && osc_ok;
			end
			wtob_pkg::ST_RUN: cmd.issue = 1'b1;
			wtob_pkg::ST_DONE: cmd.load_out = !status.out_busy;
			default: ;
		endcase
	end

endmodule

### sv/wtob_datapath.sv
// Datapath of the oscillator bank: oscillator registers, wavetables, mixer, output register.
`timescale 1ns / 1ps

module wtob_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtob_pkg::dp_cmd_t             cmd,
	input  logic [wtob_pkg::OSC_W-1:0]    osc_index,
	input  logic [wtob_pkg::IDX_W-1:0]    table_index,
	input  logic [wtob_pkg::VAL_W-1:0]    table_value,
	input  logic [wtob_pkg::PHASE_W-1:0]  phase_step,
	input  logic [wtob_pkg::GAIN_W-1:0]   gain,
	output wtob_pkg::dp_status_t          status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wtob_pkg::SAMPLE_W-1:0] sample
);

	logic [wtob_pkg::PHASE_W-1:0]  phase_q [wtob_pkg::NUM_OSC];
	logic [wtob_pkg::PHASE_W-1:0]  step_q  [wtob_pkg::NUM_OSC];
	logic [wtob_pkg::GAIN_W-1:0]   gain_q  [wtob_pkg::NUM_OSC];
	logic [wtob_pkg::VAL_W-1:0]    wave_mem [wtob_pkg::MEM_DEPTH];

	logic [wtob_pkg::CNT_W-1:0]    set_sel;
	logic [wtob_pkg::MEM_AW-1:0]   wr_addr;
	logic [wtob_pkg::MEM_AW-1:0]   rd_addr;

	logic [wtob_pkg::VAL_W-1:0]    entry_s1;
	logic [wtob_pkg::GAIN_W-1:0]   gain_s1;
	logic                          valid_s1;
	logic                          nz_s1;
	logic [wtob_pkg::PROD_W-1:0]   prod_s2;
	logic                          valid_s2;
	logic                          nz_s2;

	logic [wtob_pkg::SAMPLE_W-1:0] voice;
	logic [wtob_pkg::SAMPLE_W-1:0] mix_q;
	logic [wtob_pkg::SAMPLE_W-1:0] mix_next;
	logic [wtob_pkg::SAMPLE_W-1:0] sample_q;
	logic                          out_valid_q;

	assign set_sel = wtob_pkg::CNT_W'(osc_index);
	assign wr_addr = wtob_pkg::MEM_AW'(int'(osc_index) * wtob_pkg::TABLE_DEPTH
		+ int'(table_index));
	// The table is addressed by the integer part of the 8.8 phase.
	assign rd_addr = wtob_pkg::MEM_AW'(int'(cmd.osc) * wtob_pkg::TABLE_DEPTH
		+ int'(phase_q[cmd.osc][wtob_pkg::PHASE_W-1:8]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wtob_pkg::NUM_OSC; i++) begin
				phase_q[i] <= '0;
				step_q[i]  <= '0;
				gain_q[i]  <= '0;
			end
		end else begin
			if (cmd.set_osc) begin
				step_q[set_sel]  <= phase_step;
				gain_q[set_sel]  <= gain;
				phase_q[set_sel] <= '0;
			end
			if (cmd.issue) begin
				phase_q[cmd.osc] <= phase_q[cmd.osc] + step_q[cmd.osc];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_table) begin
			wave_mem[wr_addr] <= table_value;
		end
		entry_s1 <= wave_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		gain_s1 <= gain_q[cmd.osc];
		nz_s1   <= (gain_q[cmd.osc] != '0);
		prod_s2 <= wtob_pkg::PROD_W'(entry_s1) * wtob_pkg::PROD_W'(gain_s1);
		nz_s2   <= nz_s1;
	end

	assign voice    = wtob_pkg::SAMPLE_W'(prod_s2 >> (wtob_pkg::DAC_BITS - 1));
	assign mix_next = (mix_q >> 1) + (voice >> 1);

	always_ff @(posedge clk) begin
		if (cmd.clear_mix) begin
			mix_q <= '0;
		end else if (valid_s2 && nz_s2) begin
			mix_q <= mix_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_q <= mix_q;
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign sample          = sample_q;

endmodule

### sv/wtob_checker.sv
// Port checker of the oscillator bank and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtob_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [wtob_pkg::ACTION_W-1:0] in_action,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wtob_pkg::SAMPLE_W-1:0] out_sample
);

	logic in_take;
	logic is_tick;
	logic out_stall;

	assign in_take   = in_valid && in_ready;
	assign is_tick   = (in_action == wtob_pkg::ACT_TICK);
	assign out_stall = out_valid && !out_ready;

	`ASSERT_RST(a_out_hold, out_stall |=> out_valid, "result word dropped")
	`ASSERT_RST(a_out_stable, out_stall |=> $stable(out_sample), "result word changed while stalled")
	// The block only goes busy on an accepted tick.
	`ASSERT_RST(a_busy_on_tick, $fell(in_ready) |-> $past(in_valid && is_tick), "busy without a tick")
	`ASSERT_RST(a_write_no_stall, in_take && !is_tick |=> in_ready, "write or set stalled the input")
	// A new result is only raised at the end of a tick, while the input is held off.
	`ASSERT_RST(a_result_after_run, $rose(out_valid) |-> !$past(in_ready), "result without a tick")

endmodule

bind wavetable_oscillator_bank_core wtob_checker u_wtob_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.in_action  (cmd.action),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_sample (result.sample)
);

### bench/osc_bank_checker.sv
// Checker of the oscillator bank: predicts every mixed sample and compares it on the result channel.
`timescale 1ns / 1ps

module osc_bank_checker
	import wtob_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wtob_in_if   cmd,
	wtob_out_if  result,
	output int   errors,
	output int   pending
);

	logic [PHASE_W-1:0]  phase_of [NUM_OSC];
	logic [PHASE_W-1:0]  step_of [NUM_OSC];
	logic [GAIN_W-1:0]   gain_of [NUM_OSC];
	logic [VAL_W-1:0]    wave [NUM_OSC][TABLE_DEPTH];
	logic [SAMPLE_W-1:0] expected_samples [$];

	// Mixes one sample over the bank and advances every phase.
	function automatic logic [SAMPLE_W-1:0] mix_next_sample();
		logic [SAMPLE_W-1:0] mix;
		logic [PROD_W-1:0]   prod;
		logic [SAMPLE_W-1:0] voice;
		mix = '0;
		for (int k = 0; k < NUM_OSC; k++) begin
			if (gain_of[k] != '0) begin
				prod  = wave[k][phase_of[k][PHASE_W-1 -: IDX_W]] * gain_of[k];
				voice = prod[DAC_BITS-1 +: SAMPLE_W];
				mix   = (mix >> 1) + (voice >> 1);
			end
			// A muted oscillator still moves its phase.
			phase_of[k] = phase_of[k] + step_of[k];
		end
		return mix;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_OSC; k++) begin
				phase_of[k] = '0;
				step_of[k]  = '0;
				gain_of[k]  = '0;
			end
			expected_samples.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			// A sample never leaves in the cycle its tick is taken, so results go first.
			if (result.valid && result.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: sample mismatch, expected none, got %h", $time, result.sample);
					errors <= errors + 1;
				end else begin
					want = expected_samples.pop_front();
					if (result.sample !== want) begin
						$display("%0t: sample mismatch, expected %h, got %h",
							$time, want, result.sample);
						errors <= errors + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.action)
					ACT_TICK: begin
						expected_samples.push_back(mix_next_sample());
					end
					ACT_WRITE: begin
						if (int'(cmd.osc_index) < NUM_OSC)
							wave[cmd.osc_index][cmd.table_index] = cmd.table_value;
					end
					ACT_SET: begin
						if (int'(cmd.osc_index) < NUM_OSC) begin
							step_of[cmd.osc_index]  = cmd.phase_step;
							gain_of[cmd.osc_index]  = cmd.gain;
							phase_of[cmd.osc_index] = '0;
						end
					end
					default: ;
				endcase
			end
			pending <= expected_samples.size();
		end
	end

endmodule

### bench/tb_top.sv
// Top of the oscillator bank testbench: clock, reset, command stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;
	import wtob_pkg::*;

	localparam action_t ACT_UNUSED  = 2'd3;
	localparam int      CYCLE_LIMIT = 400000;
	localparam int      TAIL_CYCLES = 4 * (NUM_OSC + 4);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   cycle_count;
	int   tx_gap_pct   = 15;
	int   rx_stall_pct = 69;

	wtob_in_if  cmd ();
	wtob_out_if result ();

	wavetable_oscillator_bank_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

	osc_bank_checker mix_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Valid stays high from one word to the next unless a gap is drawn.
	task automatic send_word(input action_t act, input logic [OSC_W-1:0] osc,
		input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
		input logic [PHASE_W-1:0] inc, input logic [GAIN_W-1:0] amp);
		while ($urandom_range(99) < tx_gap_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.action      <= act;
		cmd.osc_index   <= osc;
		cmd.table_index <= idx;
		cmd.table_value <= val;
		cmd.phase_step  <= inc;
		cmd.gain        <= amp;
		do @(posedge clk); while (cmd.ready !== 1'b1);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		action_t            act;
		int                 pick;
		logic [GAIN_W-1:0]  amp;
		logic [PHASE_W-1:0] inc;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45)
				act = ACT_TICK;
			else if (pick < 70)
				act = ACT_WRITE;
			else if (pick < 94)
				act = ACT_SET;
			else
				act = ACT_UNUSED;
			case ($urandom_range(9))
				0:       amp = '0;
				1:       amp = '1;
				2, 3, 4: amp = GAIN_W'($urandom_range(255, 1));
				default: amp = GAIN_W'($urandom());
			endcase
			case ($urandom_range(7))
				0:       inc = '0;
				1:       inc = '1;
				2:       inc = PHASE_W'($urandom_range(1023, 1));
				default: inc = PHASE_W'($urandom());
			endcase
			send_word(act, OSC_W'($urandom()), IDX_W'($urandom()), VAL_W'($urandom()),
				inc, amp);
		end
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[wavetable_oscillator_bank_core] ERROR");
		$finish;
	end

	initial begin
		cmd.valid       = 1'b0;
		cmd.action      = ACT_TICK;
		cmd.osc_index   = '0;
		cmd.table_index = '0;
		cmd.table_value = '0;
		cmd.phase_step  = '0;
		cmd.gain        = '0;
		result.ready    = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Every table entry is loaded before any tick, so no tick reads an unwritten one.
		for (int o = 0; o < NUM_OSC; o++) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				send_word(ACT_WRITE, OSC_W'(o), IDX_W'(i),
					(i == 0) ? {VAL_W{1'b1}} :
					(i == TABLE_DEPTH - 1) ? {VAL_W{1'b0}} : VAL_W'($urandom()),
					PHASE_W'($urandom()), GAIN_W'($urandom()));
			end
		end

		// All gains are still zero here, so the first tick mixes nothing.
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_WRITE, 2'd3, {IDX_W{1'b1}}, {VAL_W{1'b1}}, '0, '0);
		send_word(ACT_SET, 2'd0, '0, '0, 16'h0100, 16'hFFFF);
		send_word(ACT_SET, 2'd1, '0, '0, 16'hFFFF, 16'h0001);
		send_word(ACT_SET, 2'd2, '0, '0, 16'h0000, 16'h0000);
		send_word(ACT_SET, 2'd3, '0, '0, 16'h8000, 16'h8000);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_TICK, 2'd3, '1, '1, '1, '1);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		// The unused action must leave the bank untouched.
		send_word(ACT_UNUSED, 2'd2, '1, '1, '1, '1);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_WRITE, 2'd2, '0, '0, '1, '1);
		send_word(ACT_SET, 2'd2, '0, '0, 16'hFFFF, 16'hFFFF);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_SET, 2'd1, '1, '1, 16'h0000, 16'h0000);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_WRITE, 2'd0, '0, '0, '0, '0);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		send_word(ACT_TICK, '0, '0, '0, '0, '0);
		wait_drained();

		send_random(170);
		wait_drained();
		tx_gap_pct   = 69;
		rx_stall_pct = 15;
		send_random(170);
		wait_drained();
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		send_random(170);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[wavetable_oscillator_bank_core] OK");
		else
			$display("[wavetable_oscillator_bank_core] ERROR");
		$finish;
	end

endmodule
